// ===== design/rstab_pkg.sv =====
package rstab_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_CLEAR       = 3'd0;
  localparam logic [2:0] REQ_INSERT      = 3'd1;
  localparam logic [2:0] REQ_DELETE      = 3'd2;
  localparam logic [2:0] REQ_LOOKUP_ID   = 3'd3;
  localparam logic [2:0] REQ_LOOKUP_KIND = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

  // Largest kind code kept in a slot; larger codes saturate on insert
  localparam logic [2:0] KIND_MAX = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] key_id;
    logic [2:0]  kind_code;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] entry_id;
    logic [2:0]  entry_kind;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } ctrl_state_t;

endpackage

// ===== design/record_slot_table.sv =====
// record_slot_table: a table of TABLE_SLOTS record slots, each with a valid
// mark, an identifier and a kind code.
// Request channel: req_valid / req_stall / req (req_type, key_id, kind_code).
// Response channel: rsp_valid / rsp_stall / rsp (status, slot_index,
// entry_id, entry_kind). Every request gives exactly one response item.
// One request is handled at a time; req_stall stays high until the
// controller is free again. Each slot is read from the table memory one per
// cycle, so the scan sets the rate: a request that stops at slot p goes on
// to commit and then done; a scan that finds nothing goes straight to done,
// and clear writes one slot at a time.
// Unknown request codes answer not found.
// After reset the table memory is swept to zero with req_stall high; the
// identifier counter starts at zero.
// The response sits in an output register; while rsp_stall is high it holds,
// the controller may finish the next item and keep it pending behind it, and
// a new request is taken once that pending item has moved to the register.
module record_slot_table import rstab_pkg::*; #(
  parameter int TABLE_SLOTS = 64,
  parameter int ID_BITS     = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  // Slot number width; a single-slot table still needs one address bit
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  // Memory word: valid mark, identifier, kind code
  localparam int ENT_W = 1 + ID_BITS + 3;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  logic      res_valid;
  logic      res_take;
  rsp_item_t res;
  logic      out_free;

  rstab_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (IDX_W),
    .DW    (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rstab_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .ID_BITS     (ID_BITS),
    .IDX_W       (IDX_W),
    .ENT_W       (ENT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: refill when empty or when the current item is taken
  assign out_free = !rsp_valid || !rsp_stall;
  assign res_take = res_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule

// ===== design/rstab_mem.sv =====
module rstab_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 20
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rstab_ctrl.sv =====
module rstab_ctrl import rstab_pkg::*; #(
  parameter int TABLE_SLOTS = 64,
  parameter int ID_BITS     = 16,
  parameter int IDX_W       = 6,
  parameter int ENT_W       = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_item_t        req,
  output logic             res_valid,
  input  logic             res_take,
  output rsp_item_t        res,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [ENT_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  logic [ENT_W-1:0] mem_rdata
);

  localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  ctrl_state_t state, state_next;

  logic [2:0]         op;
  logic [15:0]        key;
  logic [2:0]         kind;
  logic [ID_BITS-1:0] id_cnt;
  logic [IDX_W-1:0]   iss_ptr;
  logic               iss_done;
  logic               chk_vld;
  logic [IDX_W-1:0]   chk_ptr;
  logic               sweep_rsp;
  logic [IDX_W-1:0]   hit_ptr;
  logic [ID_BITS-1:0] hit_ident;
  logic [2:0]         hit_kind;

  logic               rd_valid;
  logic [ID_BITS-1:0] rd_ident;
  logic [2:0]         rd_kind;
  logic               hit;
  logic               chk_last;
  logic               accept;
  logic               exhausted;
  logic [ID_BITS-1:0] new_id;
  logic [2:0]         sat_kind;
  logic [IDX_W+5:0]   slot_wide;
  logic [ID_BITS+15:0] new_id_wide;
  logic [ID_BITS+15:0] hit_id_wide;

  assign rd_valid  = mem_rdata[ENT_W-1];
  assign rd_ident  = mem_rdata[ENT_W-2:3];
  assign rd_kind   = mem_rdata[2:0];
  assign chk_last  = (chk_ptr == LAST_SLOT);
  assign accept    = req_valid && !req_stall;
  assign exhausted = (id_cnt == ID_MAX);
  assign new_id    = id_cnt + 1'b1;
  assign sat_kind  = (kind > KIND_MAX) ? KIND_MAX : kind;
  assign slot_wide   = {6'b0, hit_ptr};
  assign new_id_wide = {16'b0, new_id};
  assign hit_id_wide = {16'b0, hit_ident};

  // Slot test for the request in hand
  always_comb begin
    case (op)
      REQ_INSERT:               hit = !rd_valid;
      REQ_DELETE, REQ_LOOKUP_ID: hit = rd_valid && (CMP_W'(rd_ident) == CMP_W'(key));
      REQ_LOOKUP_KIND:          hit = rd_valid && (rd_kind == kind);
      default:                  hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = iss_ptr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = iss_ptr;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          case (req.req_type)
            REQ_CLEAR: state_next = S_SWEEP;
            REQ_INSERT, REQ_DELETE, REQ_LOOKUP_ID, REQ_LOOKUP_KIND: state_next = S_SCAN;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        mem_we = 1'b1;
        if (iss_ptr == LAST_SLOT) begin
          state_next = sweep_rsp ? S_DONE : S_IDLE;
        end
      end
      S_SCAN: begin
        mem_re = !iss_done;
        if (chk_vld && hit) begin
          state_next = S_COMMIT;
        end else if (chk_vld && chk_last) begin
          state_next = S_DONE;
        end
      end
      S_COMMIT: begin
        mem_waddr = hit_ptr;
        case (op)
          REQ_INSERT: begin
            mem_we    = !exhausted;
            mem_wdata = {1'b1, new_id, sat_kind};
          end
          REQ_DELETE: mem_we = 1'b1;
          default:    mem_we = 1'b0;
        endcase
        state_next = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_cnt    <= '0;
      iss_ptr   <= '0;
      iss_done  <= 1'b0;
      chk_vld   <= 1'b0;
      sweep_rsp <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= req.req_type;
            key       <= req.key_id;
            kind      <= req.kind_code;
            iss_ptr   <= '0;
            iss_done  <= 1'b0;
            chk_vld   <= 1'b0;
            sweep_rsp <= 1'b1;
            res       <= '{STAT_NOT_FOUND, 6'd0, 16'd0, 3'd0};
          end
        end
        S_SWEEP: begin
          iss_ptr <= iss_ptr + 1'b1;
          res     <= '{STAT_OK, 6'd0, 16'd0, 3'd0};
        end
        S_SCAN: begin
          chk_vld <= !iss_done;
          chk_ptr <= iss_ptr;
          if (!iss_done) begin
            iss_ptr  <= iss_ptr + 1'b1;
            iss_done <= (iss_ptr == LAST_SLOT);
          end
          if (chk_vld && hit) begin
            hit_ptr   <= chk_ptr;
            hit_ident <= rd_ident;
            hit_kind  <= rd_kind;
          end else if (chk_vld && chk_last) begin
            res <= '{(op == REQ_INSERT) ? STAT_FULL : STAT_NOT_FOUND, 6'd0, 16'd0, 3'd0};
          end
        end
        S_COMMIT: begin
          if (op == REQ_INSERT) begin
            if (exhausted) begin
              res <= '{STAT_EXHAUSTED, 6'd0, 16'd0, 3'd0};
            end else begin
              id_cnt <= new_id;
              res    <= '{STAT_OK, slot_wide[5:0], new_id_wide[15:0], sat_kind};
            end
          end else begin
            res <= '{STAT_OK, slot_wide[5:0], hit_id_wide[15:0], hit_kind};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The identifier counter only ever steps up by one
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (id_cnt == $past(id_cnt)) || (id_cnt == ID_BITS'($past(id_cnt) + 1'b1)))
    else $error("identifier counter moved by other than one");

  // An insert never writes a slot once identifiers are used up
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && op == REQ_INSERT && mem_we) |-> !exhausted)
    else $error("insert committed with exhausted identifiers");

  // A pending result is held until the output stage takes it
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result dropped or changed");

  // An accepted item always leaves the idle state
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item left the controller idle");

endmodule
